// ===== design/fmrc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the framed message receiver.
package fmrc_pkg;

  localparam int unsigned ERR_CNT_BITS_DEFAULT = 16;
  localparam int unsigned ERR_CNT_OUT_BITS     = 16;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] CRC_POLY  = 8'h31;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_CRC_GOOD = 2'd1,
    KIND_CRC_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [7:0]                    payload_byte;
    logic [ERR_CNT_OUT_BITS-1:0]   error_count;
  } result_t;

  // MSB-first CRC-8 over one byte, polynomial 0x31.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/fmrc_if.sv =====
// Valid/ready channel interfaces for received bytes and for result beats.
interface fmrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmrc_res_if
  import fmrc_pkg::*;
;
  logic                        valid;
  logic                        ready;
  kind_t                       kind;
  logic [7:0]                  payload_byte;
  logic [ERR_CNT_OUT_BITS-1:0] error_count;

  modport source (output valid, output kind, output payload_byte, output error_count,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input error_count,
                  output ready);
endinterface

// ===== design/fmrc_parser.sv =====
// Frame parser: sync hunt, length, payload and CRC check with the bad frame counter.
module fmrc_parser
  import fmrc_pkg::*;
#(
  parameter int unsigned ERROR_COUNT_BITS = ERR_CNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t                      phase, phase_next;
  logic [7:0]                  bytes_left, bytes_left_next;
  logic [7:0]                  running_crc, running_crc_next;
  logic [ERROR_COUNT_BITS-1:0] bad_frames, bad_frames_next;
  logic [31:0]                 bad_ext;
  kind_t                       res_kind;
  logic [7:0]                  res_payload;
  logic [7:0]                  crc_upd;

  assign crc_upd = crc8_update(running_crc, rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT1;
      bytes_left  <= '0;
      running_crc <= '0;
      bad_frames  <= '0;
    end else begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_crc <= running_crc_next;
      bad_frames  <= bad_frames_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_crc_next = running_crc;
    bad_frames_next  = bad_frames;
    res_valid        = 1'b0;
    res_kind         = KIND_PAYLOAD;
    res_payload      = '0;
    if (accept) begin
      case (phase)
        PH_HUNT2: begin
          if (rx_byte == SYNC_BYTE) begin
            running_crc_next = crc_upd;
            phase_next       = PH_LEN;
          end else begin
            phase_next = PH_HUNT1;
          end
        end
        PH_LEN: begin
          running_crc_next = crc_upd;
          bytes_left_next  = rx_byte;
          phase_next       = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          bytes_left_next  = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CRC;
          end
          res_valid   = 1'b1;
          res_kind    = KIND_PAYLOAD;
          res_payload = rx_byte;
        end
        PH_CRC: begin
          if (rx_byte == running_crc) begin
            res_kind = KIND_CRC_GOOD;
          end else begin
            res_kind = KIND_CRC_BAD;
            if (bad_frames != '1) begin
              bad_frames_next = bad_frames + ERROR_COUNT_BITS'(1);
            end
          end
          phase_next       = PH_HUNT1;
          running_crc_next = '0;
          bytes_left_next  = '0;
          res_valid        = 1'b1;
        end
        default: begin
          // Hunting the first sync byte; unused phase codes behave the same.
          if (rx_byte == SYNC_BYTE) begin
            running_crc_next = crc8_update(8'd0, rx_byte);
            phase_next       = PH_HUNT2;
          end else begin
            phase_next = PH_HUNT1;
          end
        end
      endcase
    end
  end

  assign bad_ext = 32'(bad_frames_next);
  assign res     = '{kind: res_kind, payload_byte: res_payload,
                     error_count: bad_ext[ERR_CNT_OUT_BITS-1:0]};

  a_crc_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_CRC) |=> (phase == PH_HUNT1 && running_crc == 8'd0))
    else $error("frame end did not restart the hunt and the CRC");

  a_payload_in_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_PAYLOAD) |-> (phase == PH_PAYLOAD))
    else $error("payload beat outside the payload phase");

  a_count_only_on_bad: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && res.kind == KIND_CRC_BAD) |=> $stable(bad_frames))
    else $error("bad frame counter moved without a bad frame");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (bad_frames >= $past(bad_frames)))
    else $error("bad frame counter decreased");

endmodule

// ===== design/fmrc_skid.sv =====
// Output register with a skid stage, so the input side sees a registered ready.
module fmrc_skid
  import fmrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= in_valid;
        end else begin
          out_valid <= in_valid;
        end
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_valid) begin
          skid_data <= in_data;
        end
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the output register is empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !skid_valid)
    else $error("beat pushed while the skid stage is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready && !in_valid) |=> (out_valid && !skid_valid))
    else $error("skid stage did not drain into the output register");

endmodule

// ===== design/framed_message_receiver_crc8.sv =====
// Top level of the framed message receiver with CRC-8 check.
//
// The rx channel takes one received byte per beat. The receiver hunts for two
// consecutive 0xAA sync bytes, then reads a length byte, that many payload
// bytes and one CRC-8 byte (polynomial 0x31, initial value zero, MSB first,
// no final XOR) computed over the sync, length and payload bytes.
// The res channel delivers one beat for each payload byte (kind payload) and
// one beat at the CRC byte (kind good or bad). Sync, length and discarded
// hunt bytes produce no beat. Every result carries the bad frame count so
// far; the counter saturates at its maximum and shows its low 16 bits.
// Each result beat is registered in the output register, or in the skid stage
// when res stalls, before it shows on res. One byte is taken per cycle while
// rx.ready is high; the parser updates phase, length counter and CRC together.
// When the res side stalls, the output register and a one-beat skid stage
// absorb up to two results; rx.ready then drops until the skid drains, and no
// beat is lost or repeated. Synchronous reset returns the parser to hunting
// the first sync byte, clears the CRC, length and error count, and empties
// both output stages.
module framed_message_receiver_crc8
  import fmrc_pkg::*;
#(
  parameter int unsigned ERROR_COUNT_BITS = ERR_CNT_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  fmrc_rx_if.sink  rx,
  fmrc_res_if.source res
);

  logic    accept;
  logic    skid_ready;
  logic    par_valid;
  result_t par_res;
  result_t out_res;

  // A byte is taken whenever the skid stage has room; the parser then updates
  // in the same edge and pushes at most one result into the output stage.
  assign rx.ready = skid_ready;
  assign accept   = rx.valid && skid_ready;

  fmrc_parser #(
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .res_valid (par_valid),
    .res       (par_res)
  );

  fmrc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (par_valid),
    .in_ready  (skid_ready),
    .in_data   (par_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_res)
  );

  assign res.kind         = out_res.kind;
  assign res.payload_byte = out_res.payload_byte;
  assign res.error_count  = out_res.error_count;

endmodule
